// File: src/strided_slice_address_generator_defines.svh
// Assertion helpers shared by the address generator RTL.
// Every macro samples on the rising edge of clock and is quiet during reset.
`ifndef STRIDED_SLICE_ADDRESS_GENERATOR_DEFINES_SVH
`define STRIDED_SLICE_ADDRESS_GENERATOR_DEFINES_SVH

// Condition holds at every edge.
`define SSAG_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SSAG_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SSAG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/ssag_pkg.sv
`timescale 1ns / 1ps
package ssag_pkg;

   localparam int DEFAULT_MAX_DIMS   = 4;
   localparam int DEFAULT_COORD_BITS = 16;
   localparam int INDEX_BITS         = 64;
   localparam int DESC_BITS          = 64;
   localparam int ACTIVE_BITS        = 3;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int NUM_DESC_REGS      = 4;

   // Descriptor field positions
   localparam int EXTENT_LSB = 48;
   localparam int BEGIN_LSB  = 32;
   localparam int SIZE_LSB   = 16;
   localparam int STEP_LSB   = 0;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_ACTIVE_DIMS = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIM0_DESC   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIM3_DESC   = 3'd4;

   // Per-dimension load from the stride setup sequencer
   typedef struct packed {
      logic                  load;
      logic [INDEX_BITS-1:0] base;
      logic [INDEX_BITS-1:0] delta;
   } ssag_load_type;

   // One response entry
   typedef struct packed {
      logic [INDEX_BITS-1:0] source_index;
      logic [INDEX_BITS-1:0] dest_index;
      logic                  last;
      logic                  error;
   } ssag_rsp_type;

endpackage

// File: src/ssag_cell.sv
`timescale 1ns / 1ps
module ssag_cell #(
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  ssag_pkg::ssag_load_type             load_i,
   input  logic [COORD_BITS-1:0]               dim_first,
   input  logic [COORD_BITS-1:0]               dim_size,
   input  logic [COORD_BITS-1:0]               dim_step,
   input  logic                                active,
   input  logic                                carry_in,
   input  logic                                take,
   input  logic                                walk_en,
   input  logic                                restart,
   output logic                                carry_out,
   output logic [ssag_pkg::INDEX_BITS-1:0]     contrib
);
   import ssag_pkg::*;

   logic [COORD_BITS-1:0] pos_ff;
   logic [INDEX_BITS-1:0] contrib_ff;
   logic [INDEX_BITS-1:0] base_ff;
   logic [INDEX_BITS-1:0] delta_ff;

   logic [COORD_BITS-1:0] pos_eff;
   logic [INDEX_BITS-1:0] contrib_eff;
   logic [COORD_BITS:0]   pos_stepped;
   logic [COORD_BITS:0]   pos_end;
   logic                  wrap;
   logic                  advance;

   // restart drops the walk back to the first element before this request
   assign pos_eff     = restart ? dim_first : pos_ff;
   assign contrib_eff = restart ? base_ff : contrib_ff;
   assign pos_stepped = {1'b0, pos_eff} + {1'b0, dim_step};
   assign pos_end     = {1'b0, dim_first} + {1'b0, dim_size};
   assign wrap        = (pos_stepped >= pos_end);
   assign advance     = walk_en && active && carry_in;
   assign carry_out   = active && carry_in && wrap;
   assign contrib     = contrib_eff;

   always_ff @(posedge clock) begin
      if (load_i.load) begin
         base_ff    <= load_i.base;
         delta_ff   <= load_i.delta;
         contrib_ff <= load_i.base;
         pos_ff     <= dim_first;
      end else if (take) begin
         if (advance && wrap) begin
            pos_ff     <= dim_first;
            contrib_ff <= base_ff;
         end else if (advance) begin
            pos_ff     <= pos_stepped[COORD_BITS-1:0];
            contrib_ff <= contrib_eff + delta_ff;
         end else begin
            pos_ff     <= pos_eff;
            contrib_ff <= contrib_eff;
         end
      end
   end

endmodule

// File: src/ssag_setup.sv
`timescale 1ns / 1ps
module ssag_setup #(
   parameter int MAX_DIMS   = 4,
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [MAX_DIMS-1:0]           dim_active,
   input  logic [COORD_BITS-1:0]         dim_extent [MAX_DIMS],
   input  logic [COORD_BITS-1:0]         dim_first  [MAX_DIMS],
   input  logic [COORD_BITS-1:0]         dim_step   [MAX_DIMS],
   output logic                          busy,
   output ssag_pkg::ssag_load_type       load_o     [MAX_DIMS]
);
   import ssag_pkg::*;

   localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int BW = $clog2(COORD_BITS);

   typedef enum logic {IDLE, RUN} state_type;

   state_type             state_ff, state_in;
   logic [DW-1:0]         dim_ff, dim_in;
   logic [BW-1:0]         bit_ff, bit_in;
   logic [INDEX_BITS-1:0] stride_ff, stride_in;
   logic [INDEX_BITS-1:0] mcand_ff, mcand_in;
   logic [INDEX_BITS-1:0] acc_base_ff, acc_base_in;
   logic [INDEX_BITS-1:0] acc_delta_ff, acc_delta_in;
   logic [INDEX_BITS-1:0] acc_stride_ff, acc_stride_in;

   logic [INDEX_BITS-1:0] base_sum, delta_sum, stride_sum, stride_next;
   logic                  last_bit;
   logic [DW-1:0]         next_dim;

   // One shift-add step per cycle for begin, step and extent of one dimension
   assign base_sum    = acc_base_ff + (dim_first[dim_ff][bit_ff] ? mcand_ff : '0);
   assign delta_sum   = acc_delta_ff + (dim_step[dim_ff][bit_ff] ? mcand_ff : '0);
   assign stride_sum  = acc_stride_ff + (dim_extent[dim_ff][bit_ff] ? mcand_ff : '0);
   assign last_bit    = (bit_ff == BW'(COORD_BITS - 1));
   assign stride_next = dim_active[dim_ff] ? stride_sum : stride_ff;
   assign next_dim    = dim_ff - DW'(1);
   assign busy        = (state_ff == RUN);

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         load_o[d].load  = (state_ff == RUN) && last_bit && (dim_ff == DW'(d));
         load_o[d].base  = base_sum;
         load_o[d].delta = delta_sum;
      end
   end

   always_comb begin
      state_in      = state_ff;
      dim_in        = dim_ff;
      bit_in        = bit_ff;
      stride_in     = stride_ff;
      mcand_in      = mcand_ff;
      acc_base_in   = acc_base_ff;
      acc_delta_in  = acc_delta_ff;
      acc_stride_in = acc_stride_ff;
      if (start) begin
         state_in      = RUN;
         dim_in        = DW'(MAX_DIMS - 1);
         bit_in        = '0;
         stride_in     = INDEX_BITS'(1);
         mcand_in      = dim_active[MAX_DIMS-1] ? INDEX_BITS'(1) : '0;
         acc_base_in   = '0;
         acc_delta_in  = '0;
         acc_stride_in = '0;
      end else if (state_ff == RUN) begin
         if (last_bit) begin
            // move out one dimension; inactive ones contribute nothing
            stride_in     = stride_next;
            bit_in        = '0;
            acc_base_in   = '0;
            acc_delta_in  = '0;
            acc_stride_in = '0;
            if (dim_ff == '0) begin
               state_in = IDLE;
            end else begin
               dim_in   = next_dim;
               mcand_in = dim_active[next_dim] ? stride_next : '0;
            end
         end else begin
            bit_in        = bit_ff + BW'(1);
            mcand_in      = {mcand_ff[INDEX_BITS-2:0], 1'b0};
            acc_base_in   = base_sum;
            acc_delta_in  = delta_sum;
            acc_stride_in = stride_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      dim_ff        <= dim_in;
      bit_ff        <= bit_in;
      stride_ff     <= stride_in;
      mcand_ff      <= mcand_in;
      acc_base_ff   <= acc_base_in;
      acc_delta_ff  <= acc_delta_in;
      acc_stride_ff <= acc_stride_in;
   end

endmodule

// File: src/ssag_rsp_fifo.sv
`timescale 1ns / 1ps
module ssag_rsp_fifo #(
   parameter int DEPTH = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ssag_pkg::ssag_rsp_type push_data,
   input  logic                   pop,
   output logic                   valid,
   output ssag_pkg::ssag_rsp_type data
);
   import ssag_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ssag_rsp_type  mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign valid = (count_ff != '0);
   assign data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         count_ff <= count_ff + CW'(push) - CW'(pop);
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/strided_slice_address_generator.sv
// Strided slice address generator: one source/destination index pair per request.
// A response crosses the sum pipeline, which adds one dimension's contribution per stage,
//   and then the response queue before it shows on rsp_valid.
// Throughput: one request per cycle while req_stall is low; the carry chain of dimension cells is combinational.
// Reset and every write inside the register list start a stride setup
//   (one shift-add step per coordinate bit and dimension) with req_stall high.
`timescale 1ns / 1ps
`include "strided_slice_address_generator_defines.svh"
module strided_slice_address_generator #(
   parameter int MAX_DIMS   = ssag_pkg::DEFAULT_MAX_DIMS,
   parameter int COORD_BITS = ssag_pkg::DEFAULT_COORD_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_restart,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ssag_pkg::INDEX_BITS-1:0]       rsp_source_index,
   output logic [ssag_pkg::INDEX_BITS-1:0]       rsp_dest_index,
   output logic                                  rsp_last,
   output logic                                  rsp_error,
   // register write port
   input  logic                                  csr_write_enable,
   input  logic [ssag_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ssag_pkg::DESC_BITS-1:0]        csr_write_data
);
   import ssag_pkg::*;

   // Room for every request in the sum pipeline plus a little slack in the response queue
   localparam int DEPTH = MAX_DIMS + 2;
   localparam int CW    = $clog2(DEPTH + 1);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [ACTIVE_BITS-1:0] active_ff;
   logic [DESC_BITS-1:0]   desc_ff [MAX_DIMS];
   logic                   cfg_hit;
   logic                   start_ff;

   // Any write inside the register list restarts the walk
   assign cfg_hit = csr_write_enable && (csr_index <= REG_DIM3_DESC);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_BITS'(1);
         for (int d = 0; d < MAX_DIMS; d++) begin
            desc_ff[d] <= '0;
         end
         start_ff <= 1'b1;
      end else begin
         if (csr_write_enable && csr_index == REG_ACTIVE_DIMS) begin
            active_ff <= csr_write_data[ACTIVE_BITS-1:0];
         end
         // descriptors past the register list stay zero
         for (int d = 0; d < MAX_DIMS; d++) begin
            if (d < NUM_DESC_REGS && csr_write_enable &&
                csr_index == REG_DIM0_DESC + CSR_INDEX_BITS'(d)) begin
               desc_ff[d] <= csr_write_data;
            end
         end
         start_ff <= cfg_hit;
      end
   end

   // ------------------------------------------------------------------
   // Descriptor fields and validity
   // ------------------------------------------------------------------
   logic [COORD_BITS-1:0] dim_extent [MAX_DIMS];
   logic [COORD_BITS-1:0] dim_first  [MAX_DIMS];
   logic [COORD_BITS-1:0] dim_size   [MAX_DIMS];
   logic [COORD_BITS-1:0] dim_step   [MAX_DIMS];
   logic [COORD_BITS:0]   dim_reach  [MAX_DIMS];
   logic [MAX_DIMS-1:0]   dim_active;
   logic [MAX_DIMS-1:0]   dim_inner;
   logic                  cfg_bad;

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         dim_extent[d] = desc_ff[d][EXTENT_LSB +: COORD_BITS];
         dim_first[d]  = desc_ff[d][BEGIN_LSB +: COORD_BITS];
         dim_size[d]   = desc_ff[d][SIZE_LSB +: COORD_BITS];
         dim_step[d]   = desc_ff[d][STEP_LSB +: COORD_BITS];
         dim_reach[d]  = {1'b0, dim_first[d]} + {1'b0, dim_size[d]};
         dim_active[d] = (ACTIVE_BITS'(d) < active_ff);
         dim_inner[d]  = (ACTIVE_BITS'(d + 1) == active_ff);
      end
   end

   // Flag a bad active dimension count, out-of-range begin, overrunning size, zero step and empty dimensions
   always_comb begin
      cfg_bad = (active_ff == '0) || (active_ff > ACTIVE_BITS'(MAX_DIMS));
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (dim_active[d] &&
             ((dim_first[d] >= dim_extent[d]) ||
              (dim_reach[d] > {1'b0, dim_extent[d]}) ||
              (dim_step[d] == '0) || (dim_size[d] == '0))) begin
            cfg_bad = 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stride setup: base and step offsets of every dimension
   // ------------------------------------------------------------------
   ssag_load_type setup_load [MAX_DIMS];
   logic          setup_busy;

   ssag_setup #(
      .MAX_DIMS   (MAX_DIMS),
      .COORD_BITS (COORD_BITS)
   ) u_setup (
      .clock      (clock),
      .reset      (reset),
      .start      (start_ff),
      .dim_active (dim_active),
      .dim_extent (dim_extent),
      .dim_first  (dim_first),
      .dim_step   (dim_step),
      .busy       (setup_busy),
      .load_o     (setup_load)
   );

   // ------------------------------------------------------------------
   // Request acceptance
   // ------------------------------------------------------------------
   logic          req_accept;
   logic          rsp_pop;
   logic [CW-1:0] cnt_ff;

   // cnt_ff counts requests in the sum pipeline and in the response queue
   assign req_stall  = start_ff || setup_busy || cfg_hit || (cnt_ff == CW'(DEPTH));
   assign req_accept = req_valid && !req_stall;
   assign rsp_pop    = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + CW'(req_accept) - CW'(rsp_pop);
      end
   end

   // ------------------------------------------------------------------
   // Dimension cells: carry ripples from innermost toward dimension 0
   // ------------------------------------------------------------------
   logic [MAX_DIMS-1:0]   carry_in;
   logic [MAX_DIMS-1:0]   carry_out;
   logic [INDEX_BITS-1:0] contrib [MAX_DIMS];
   logic                  walk_last;

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_cell
      if (d == MAX_DIMS - 1) begin : g_edge
         assign carry_in[d] = dim_inner[d];
      end else begin : g_mid
         assign carry_in[d] = dim_inner[d] || carry_out[d+1];
      end

      ssag_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock     (clock),
         .load_i    (setup_load[d]),
         .dim_first (dim_first[d]),
         .dim_size  (dim_size[d]),
         .dim_step  (dim_step[d]),
         .active    (dim_active[d]),
         .carry_in  (carry_in[d]),
         .take      (req_accept),
         .walk_en   (!cfg_bad),
         .restart   (req_restart),
         .carry_out (carry_out[d]),
         .contrib   (contrib[d])
      );
   end

   // Carry out of dimension 0 means every dimension wrapped: final element
   assign walk_last = carry_out[0];

   // ------------------------------------------------------------------
   // Destination count
   // ------------------------------------------------------------------
   logic [INDEX_BITS-1:0] dest_ff;
   logic [INDEX_BITS-1:0] dest_eff;

   assign dest_eff = req_restart ? '0 : dest_ff;

   always_ff @(posedge clock) begin
      if (reset || start_ff) begin
         dest_ff <= '0;
      end else if (req_accept) begin
         if (cfg_bad) begin
            dest_ff <= dest_eff;
         end else if (walk_last) begin
            dest_ff <= '0;
         end else begin
            dest_ff <= dest_eff + INDEX_BITS'(1);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sum pipeline: stage s adds the contribution of dimension s
   // ------------------------------------------------------------------
   ssag_rsp_type          pipe_ff    [MAX_DIMS];
   logic [INDEX_BITS-1:0] pipe_vec_ff [MAX_DIMS][MAX_DIMS];
   logic [MAX_DIMS-1:0]   pipe_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
      end else begin
         pipe_valid_ff[0] <= req_accept;
         for (int s = 1; s < MAX_DIMS; s++) begin
            pipe_valid_ff[s] <= pipe_valid_ff[s-1];
         end
      end
      // error responses carry zero indices: drop every contribution
      pipe_ff[0].source_index <= cfg_bad ? '0 : contrib[0];
      pipe_ff[0].dest_index   <= cfg_bad ? '0 : dest_eff;
      pipe_ff[0].last         <= !cfg_bad && walk_last;
      pipe_ff[0].error        <= cfg_bad;
      for (int d = 0; d < MAX_DIMS; d++) begin
         pipe_vec_ff[0][d] <= cfg_bad ? '0 : contrib[d];
      end
      for (int s = 1; s < MAX_DIMS; s++) begin
         pipe_ff[s].source_index <= pipe_ff[s-1].source_index + pipe_vec_ff[s-1][s];
         pipe_ff[s].dest_index   <= pipe_ff[s-1].dest_index;
         pipe_ff[s].last         <= pipe_ff[s-1].last;
         pipe_ff[s].error        <= pipe_ff[s-1].error;
         for (int d = 0; d < MAX_DIMS; d++) begin
            pipe_vec_ff[s][d] <= pipe_vec_ff[s-1][d];
         end
      end
   end

   // ------------------------------------------------------------------
   // Response queue
   // ------------------------------------------------------------------
   ssag_rsp_type rsp_data;

   ssag_rsp_fifo #(
      .DEPTH (DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (pipe_valid_ff[MAX_DIMS-1]),
      .push_data (pipe_ff[MAX_DIMS-1]),
      .pop       (rsp_pop),
      .valid     (rsp_valid),
      .data      (rsp_data)
   );

   assign rsp_source_index = rsp_data.source_index;
   assign rsp_dest_index   = rsp_data.dest_index;
   assign rsp_last         = rsp_data.last;
   assign rsp_error        = rsp_data.error;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `SSAG_ASSERT_ALWAYS(a_cnt_bound, cnt_ff <= CW'(DEPTH), "request count overran the queue")
   `SSAG_ASSERT_IMPL(a_error_zero, rsp_valid && rsp_error,
      rsp_source_index == '0 && rsp_dest_index == '0 && !rsp_last,
      "error response with nonzero indices")
   `SSAG_ASSERT_NEXT(a_dest_step, req_accept && !cfg_bad && !walk_last && !start_ff,
      dest_ff == $past(dest_eff) + INDEX_BITS'(1), "destination count did not advance")
   `SSAG_ASSERT_NEXT(a_setup_runs, start_ff, setup_busy, "stride setup did not start")

endmodule
